/* design/hgm_pkg.sv */
`timescale 1ns / 1ps
// hgm_pkg: shared types, codes and hex-step tables for the hex grid led index mapper
// no dependencies; imported by the column table, the top level and the checker

package hgm_pkg;

    // item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_XY   = 2'd1;
    localparam logic [1:0] KIND_NBR  = 2'd2;

    // one column table entry
    typedef struct packed {
        logic [7:0] row_start;
        logic [7:0] height;
        logic [7:0] first_index;
    } hgm_entry_t;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_STEP  = 4'b0100,
        S_CHECK = 4'b1000
    } hgm_state_t;

    // direction modulo six by reciprocal multiply (171/1024 ~ 1/6, exact for 8 bits)
    function automatic logic [2:0] dir_mod6(input logic [7:0] d);
        logic [15:0] p;
        logic [7:0]  q;
        logic [7:0]  r;
        p = 16'(d) * 16'd171;
        q = {2'b00, p[15:10]};
        r = d - 8'(q * 8'd6);
        return r[2:0];
    endfunction

    // column change per direction
    function automatic logic signed [7:0] step_col(input logic [2:0] dir);
        logic signed [7:0] s;
        case (dir)
            3'd1, 3'd2: s = 8'sd1;
            3'd4, 3'd5: s = -8'sd1;
            default:    s = 8'sd0;
        endcase
        return s;
    endfunction

    // row change per direction, depends on column parity
    function automatic logic signed [7:0] step_row(input logic [2:0] dir, input logic odd);
        logic signed [7:0] s;
        if (odd)
        begin
            case (dir)
                3'd0:             s = 8'sd1;
                3'd2, 3'd3, 3'd4: s = -8'sd1;
                default:          s = 8'sd0;
            endcase
        end
        else
        begin
            case (dir)
                3'd0, 3'd1, 3'd5: s = 8'sd1;
                3'd3:             s = -8'sd1;
                default:          s = 8'sd0;
            endcase
        end
        return s;
    endfunction

endpackage

/* design/hgm_table.sv */
`timescale 1ns / 1ps
// hgm_table: per-column table memory, one write port and one registered read port
// depends on hgm_pkg for the entry type

module hgm_table
    import hgm_pkg::*;
#(
    parameter int DEPTH  = 14,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  hgm_entry_t        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output hgm_entry_t        rd_data
);

    hgm_entry_t mem [DEPTH];
    hgm_entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered, holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/hex_grid_led_index_mapper.sv */
`timescale 1ns / 1ps
// hex_grid_led_index_mapper: top level, column table sequencer and result register
// depends on hgm_pkg and hgm_table
//
// Input beats arrive on in_valid / in_stall; result beats leave on out_valid / out_stall.
// A load beat (kind 0) writes one column entry in the cycle it is taken and gives no
// result; in_stall stays low, so another beat may follow in the next cycle.
// An xy query (kind 1) reads the column entry once: its result is loaded into the
// output register from the check state, once that register is free.
// A neighbor query (kind 2) scans the first-index column of the table, one entry per
// cycle over the single read port, then reads the found column, steps and reads the
// target column before the row span check.
// One item is in work at a time; in_stall is high from acceptance until the result
// has moved into the output register. A finished result waiting under out_stall does
// not block the next beat, but the following result waits until the register drains.
// Reset clears the sequencer and the output valid; the table is not cleared and each
// column must be loaded before a query reads it.

module hex_grid_led_index_mapper
    import hgm_pkg::*;
#(
    parameter int NUM_COLUMNS = 14,
    parameter int NUM_ROWS    = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [3:0]        column,
    input  logic [7:0]        row_start,
    input  logic [7:0]        column_height,
    input  logic [7:0]        first_index,
    input  logic signed [7:0] x_coord,
    input  logic signed [7:0] y_coord,
    input  logic [8:0]        led_index,
    input  logic [7:0]        direction,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              in_bounds,
    output logic [8:0]        chain_index
);

    localparam int COL_W = $clog2(NUM_COLUMNS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLUMNS - 1);

    hgm_state_t        state_reg, state_next;
    logic [8:0]        led_reg, led_next;
    logic [2:0]        dir_reg, dir_next;
    logic [COL_W-1:0]  scan_reg, scan_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic signed [7:0] qy_reg, qy_next;
    logic              pos_ok_reg, pos_ok_next;
    logic              out_valid_reg, out_valid_next;
    logic              in_bounds_reg, in_bounds_next;
    logic [8:0]        chain_index_reg, chain_index_next;

    logic              accept;
    logic              out_free;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    hgm_entry_t        wr_data;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    hgm_entry_t        rd_data;

    logic              xy_ok;
    logic              scan_hit;
    logic [COL_W-1:0]  found_col;
    logic [7:0]        base_row;
    logic signed [7:0] nx;
    logic signed [7:0] ny;
    logic              nxy_ok;
    logic              row_ge;
    logic              row_lt;
    logic [7:0]        row_off;
    logic [8:0]        idx_sum;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // table write from load beats
    assign wr_en   = accept && (kind == KIND_LOAD) && (int'(column) < NUM_COLUMNS);
    assign wr_addr = COL_W'(column);
    assign wr_data = '{row_start: row_start, height: column_height, first_index: first_index};

    // grid bounds of an xy query
    assign xy_ok = !x_coord[7] && (x_coord[6:0] < 7'(NUM_COLUMNS))
                && !y_coord[7] && (y_coord[6:0] < 7'(NUM_ROWS));

    // column search compare
    assign scan_hit  = {1'b0, led_reg} < {2'b00, rd_data.first_index};
    assign found_col = scan_hit ? scan_reg - COL_W'(1) : scan_reg;

    // derived row of the start column and the stepped position
    assign base_row = led_reg[7:0] - rd_data.first_index + rd_data.row_start;
    assign nx       = 8'(col_reg) + step_col(dir_reg);
    assign ny       = base_row + step_row(dir_reg, col_reg[0]);
    assign nxy_ok   = !nx[7] && (nx[6:0] < 7'(NUM_COLUMNS))
                   && !ny[7] && (ny[6:0] < 7'(NUM_ROWS));

    // row span test and chain index of the checked column
    assign row_ge  = qy_reg >= rd_data.row_start;
    assign row_lt  = {1'b0, qy_reg} < ({1'b0, rd_data.row_start} + {1'b0, rd_data.height});
    assign row_off = qy_reg - rd_data.row_start;
    assign idx_sum = {1'b0, rd_data.first_index} + {1'b0, row_off};

    // sequencer and read address
    always_comb
    begin
        state_next       = state_reg;
        led_next         = led_reg;
        dir_next         = dir_reg;
        scan_next        = scan_reg;
        col_next         = col_reg;
        qy_next          = qy_reg;
        pos_ok_next      = pos_ok_reg;
        out_valid_next   = out_valid_reg && out_stall;
        in_bounds_next   = in_bounds_reg;
        chain_index_next = chain_index_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (kind == KIND_XY))
                begin
                    rd_en       = 1'b1;
                    rd_addr     = xy_ok ? x_coord[COL_W-1:0] : '0;
                    qy_next     = y_coord;
                    pos_ok_next = xy_ok;
                    state_next  = S_CHECK;
                end
                else if (accept && (kind == KIND_NBR))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = COL_W'(1);
                    scan_next  = COL_W'(1);
                    led_next   = led_index;
                    dir_next   = dir_mod6(direction);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_en = 1'b1;
                if (scan_hit || (scan_reg == LAST_COL))
                begin
                    rd_addr    = found_col;
                    col_next   = found_col;
                    state_next = S_STEP;
                end
                else
                begin
                    rd_addr   = scan_reg + COL_W'(1);
                    scan_next = scan_reg + COL_W'(1);
                end
            end
            S_STEP:
            begin
                rd_en       = 1'b1;
                rd_addr     = nxy_ok ? nx[COL_W-1:0] : '0;
                qy_next     = ny;
                pos_ok_next = nxy_ok;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    in_bounds_next   = pos_ok_reg && row_ge && row_lt;
                    chain_index_next = (pos_ok_reg && row_ge && row_lt) ? idx_sum : 9'd0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        led_reg         <= led_next;
        dir_reg         <= dir_next;
        scan_reg        <= scan_next;
        col_reg         <= col_next;
        qy_reg          <= qy_next;
        pos_ok_reg      <= pos_ok_next;
        in_bounds_reg   <= in_bounds_next;
        chain_index_reg <= chain_index_next;
    end

    hgm_table #(
        .DEPTH  (NUM_COLUMNS),
        .ADDR_W (COL_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid   = out_valid_reg;
    assign in_bounds   = in_bounds_reg;
    assign chain_index = chain_index_reg;

endmodule

/* design/hgm_checker.sv */
`timescale 1ns / 1ps
// hgm_checker: port-level assertions for hex_grid_led_index_mapper, bound to the top level
// depends on hgm_pkg for the item kind codes

module hgm_checker
    import hgm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] kind,
    input logic       out_valid,
    input logic       out_stall,
    input logic       in_bounds,
    input logic [8:0] chain_index
);

    // a stalled result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped under stall");

    // a stalled result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(in_bounds) && $stable(chain_index))
        else $error("result payload changed under stall");

    // an off-panel result carries chain index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_bounds |-> chain_index == 9'd0)
        else $error("off-panel result with nonzero chain index");

    // a load beat finishes in its own cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_LOAD |=> !in_stall)
        else $error("input stalled after a load beat");

    // a query beat occupies the sequencer, so the input is stalled after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == KIND_XY || kind == KIND_NBR) |=> in_stall)
        else $error("input not stalled after a query beat");

endmodule

bind hex_grid_led_index_mapper hgm_checker u_hgm_checker (.*);

/* verif/hex_grid_led_index_mapper_tb.sv */
`timescale 1ns / 1ps
// hex_grid_led_index_mapper_tb: self-checking bench for the hex grid led index mapper
// depends on hgm_pkg and hex_grid_led_index_mapper; predicts every result beat in order

module hex_grid_led_index_mapper_tb;
    import hgm_pkg::*;

    localparam int NUM_COLUMNS = 14;
    localparam int NUM_ROWS    = 12;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int NUM_PHASES  = 5;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 24;
    localparam int QUERIES_PER_PHASE = 192;

    // hex step per direction: column change, row change for odd and even columns
    localparam int COL_STEP [6]      = '{0, 1, 1, 0, -1, -1};
    localparam int ODD_ROW_STEP [6]  = '{1, 0, -1, -1, -1, 0};
    localparam int EVEN_ROW_STEP [6] = '{1, 1, 0, -1, 0, 1};

    // idling per phase, percent of cycles
    localparam int SEND_IDLE [NUM_PHASES]  = '{0, 61, 0, 33, 0};
    localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 61, 33, 0};

    typedef struct {
        logic [1:0]        kind;
        logic [3:0]        column;
        logic [7:0]        row_start;
        logic [7:0]        column_height;
        logic [7:0]        first_index;
        logic signed [7:0] x_coord;
        logic signed [7:0] y_coord;
        logic [8:0]        led_index;
        logic [7:0]        direction;
    } grid_beat_t;

    typedef struct {
        logic       on_panel;
        logic [8:0] idx;
    } position_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        kind = '0;
    logic [3:0]        column = '0;
    logic [7:0]        row_start = '0;
    logic [7:0]        column_height = '0;
    logic [7:0]        first_index = '0;
    logic signed [7:0] x_coord = '0;
    logic signed [7:0] y_coord = '0;
    logic [8:0]        led_index = '0;
    logic [7:0]        direction = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              in_bounds;
    logic [8:0]        chain_index;

    // shadow of the column table as the accepted beats leave it
    logic [7:0] start_row_tab [NUM_COLUMNS];
    logic [7:0] height_tab [NUM_COLUMNS];
    logic [7:0] first_led_tab [NUM_COLUMNS];

    grid_beat_t beat_backlog [$];
    position_t  expected_positions [$];
    grid_beat_t beat_on_bus;
    logic       exp_hit;
    logic [8:0] exp_idx;
    position_t  got_pos;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_arm = 1'b0;
    bit hold_used;
    int hold_left;
    int panel_end = 0;
    int mismatch_count = 0;

    hex_grid_led_index_mapper #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_dut (.*);

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // grid position to chain index, 0 when off the panel
    function automatic bit grid_lookup(input int x, input int y, output logic [8:0] idx);
        int start;
        idx = '0;
        if (x < 0 || y < 0 || x >= NUM_COLUMNS || y >= NUM_ROWS)
            return 1'b0;
        start = int'(start_row_tab[x]);
        if (y < start || y >= start + int'(height_tab[x]))
            return 1'b0;
        idx = 9'(int'(first_led_tab[x]) + y - start);
        return 1'b1;
    endfunction

    // applies one accepted beat; returns 1 when it gives a result beat
    function automatic bit predict_position(input grid_beat_t b, output logic on_panel,
                                            output logic [8:0] idx);
        int col;
        int dir;
        int nx;
        logic signed [7:0] row8;
        on_panel = 1'b0;
        idx = '0;
        case (b.kind)
            KIND_LOAD:
            begin
                if (int'(b.column) < NUM_COLUMNS)
                begin
                    start_row_tab[b.column] = b.row_start;
                    height_tab[b.column]    = b.column_height;
                    first_led_tab[b.column] = b.first_index;
                end
                return 1'b0;
            end
            KIND_XY:
                on_panel = grid_lookup(int'(b.x_coord), int'(b.y_coord), idx);
            KIND_NBR:
            begin
                dir = int'(b.direction) % 6;
                // lowest column whose successor starts above the index
                col = NUM_COLUMNS - 1;
                for (int c = NUM_COLUMNS - 1; c >= 1; c--)
                begin
                    if (b.led_index < {1'b0, first_led_tab[c]})
                        col = c - 1;
                end
                // derived row and stepped row wrap at 8 bits
                row8 = 8'(int'(b.led_index) - int'(first_led_tab[col])
                          + int'(start_row_tab[col]));
                nx = col + COL_STEP[dir];
                row8 = 8'(int'(row8) + ((col % 2 == 1) ? ODD_ROW_STEP[dir]
                                                       : EVEN_ROW_STEP[dir]));
                on_panel = grid_lookup(nx, int'(row8), idx);
            end
            default:
                return 1'b0;
        endcase
        if (!on_panel)
            idx = '0;
        return 1'b1;
    endfunction

    // every field random, the kind-specific ones set by the caller
    function automatic grid_beat_t random_beat(input logic [1:0] k);
        grid_beat_t b;
        b.kind          = k;
        b.column        = 4'($urandom);
        b.row_start     = 8'($urandom);
        b.column_height = 8'($urandom);
        b.first_index   = 8'($urandom);
        b.x_coord       = 8'($urandom);
        b.y_coord       = 8'($urandom);
        b.led_index     = 9'($urandom);
        b.direction     = 8'($urandom);
        return b;
    endfunction

    task automatic queue_load(input int c, input int rs, input int ht, input int fi);
        grid_beat_t b;
        b = random_beat(KIND_LOAD);
        b.column        = 4'(c);
        b.row_start     = 8'(rs);
        b.column_height = 8'(ht);
        b.first_index   = 8'(fi);
        beat_backlog.push_back(b);
    endtask

    task automatic queue_xy(input int x, input int y);
        grid_beat_t b;
        b = random_beat(KIND_XY);
        b.x_coord = 8'(x);
        b.y_coord = 8'(y);
        beat_backlog.push_back(b);
    endtask

    task automatic queue_nbr(input int led, input int dir);
        grid_beat_t b;
        b = random_beat(KIND_NBR);
        b.led_index = 9'(led);
        b.direction = 8'(dir);
        beat_backlog.push_back(b);
    endtask

    // loads all columns: a chained panel, or random bytes when scrambled is set
    task automatic queue_panel(input bit scrambled);
        int acc;
        int ht;
        acc = $urandom_range(0, 80);
        for (int c = 0; c < NUM_COLUMNS; c++)
        begin
            ht = $urandom_range(0, NUM_ROWS);
            if (scrambled)
                queue_load(c, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
            else
                queue_load(c, $urandom_range(0, 3), ht, acc);
            acc += ht;
        end
        panel_end = scrambled ? 255 : acc;
    endtask

    // mostly in-range queries against the current panel, with reloads and noise
    task automatic queue_random_stream(input int n);
        int made;
        int pick;
        grid_beat_t b;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_xy($urandom_range(0, 255), $urandom_range(0, 255));
                else
                    queue_xy(int'($urandom_range(0, NUM_COLUMNS + 3)) - 2,
                             int'($urandom_range(0, NUM_ROWS + 3)) - 2);
                made++;
            end
            else if (pick < 85)
            begin
                if ($urandom_range(0, 6) == 0)
                    queue_nbr($urandom_range(0, 511), $urandom_range(0, 255));
                else
                    queue_nbr($urandom_range(0, panel_end + 8), $urandom_range(0, 255));
                made++;
            end
            else if (pick < 90)
                queue_load($urandom_range(0, NUM_COLUMNS - 1), $urandom_range(0, 3),
                           $urandom_range(0, NUM_ROWS), $urandom_range(0, 255));
            else if (pick < 97)
            begin
                // unused kind or a load past the table
                b = random_beat($urandom_range(0, 1) ? KIND_UNUSED : KIND_LOAD);
                if (b.kind == KIND_LOAD)
                    b.column = 4'($urandom_range(NUM_COLUMNS, 15));
                beat_backlog.push_back(b);
            end
            else
                queue_panel($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic wait_drained();
        while (beat_backlog.size() != 0 || in_valid || expected_positions.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // input driver: predicts each taken beat, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (predict_position(beat_on_bus, exp_hit, exp_idx))
                    expected_positions.push_back('{exp_hit, exp_idx});
            end
            if (!in_valid || !in_stall)
            begin
                if (beat_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    beat_on_bus = beat_backlog.pop_front();
                    kind          <= beat_on_bus.kind;
                    column        <= beat_on_bus.column;
                    row_start     <= beat_on_bus.row_start;
                    column_height <= beat_on_bus.column_height;
                    first_index   <= beat_on_bus.first_index;
                    x_coord       <= beat_on_bus.x_coord;
                    y_coord       <= beat_on_bus.y_coord;
                    led_index     <= beat_on_bus.led_index;
                    direction     <= beat_on_bus.direction;
                    in_valid      <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, started once in the pressure phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_arm && !hold_used)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor: checks each taken result beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_positions.size() == 0)
                    report_mismatch($sformatf("unexpected result beat in_bounds=%0b idx=%0d",
                                              in_bounds, chain_index));
                else
                begin
                    got_pos = expected_positions.pop_front();
                    if (in_bounds !== got_pos.on_panel)
                        report_mismatch($sformatf("in_bounds %0b, expected %0b",
                                                  in_bounds, got_pos.on_panel));
                    if (chain_index !== got_pos.idx)
                        report_mismatch($sformatf("chain_index %0d, expected %0d",
                                                  chain_index, got_pos.idx));
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // stimulus and phase control, all updates on the falling edge
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            hold_arm       = (ph == PRESSURE_PHASE);
            if (ph == 0)
            begin
                // every column loaded before anything reads the table
                queue_panel(1'b0);
                queue_load(15, 255, 255, 255);
                queue_load(NUM_COLUMNS, 255, 255, 255);
                beat_backlog.push_back(random_beat(KIND_UNUSED));
                // corners and extremes of the xy fields
                queue_xy(0, 0);
                queue_xy(NUM_COLUMNS - 1, NUM_ROWS - 1);
                queue_xy(-128, -128);
                queue_xy(127, 127);
                queue_xy(5, -1);
                // all six directions, lowest and highest index
                queue_nbr(0, 0);
                queue_nbr(511, 255);
                queue_nbr(30, 1);
                queue_nbr(30, 2);
                queue_nbr(30, 4);
                queue_nbr(30, 5);
                // all-ones entry in the last column, derived row wraps
                queue_load(NUM_COLUMNS - 1, 255, 255, 255);
                queue_nbr(255, 0);
            end
            queue_random_stream(QUERIES_PER_PHASE);
            wait_drained();
        end
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
